[sv/msspan_pkg.sv]
package msspan_pkg;

  localparam int PRICE_W = 32;
  localparam int SPAN_W  = 32;

  typedef logic signed [PRICE_W-1:0] price_t;
  typedef logic [SPAN_W-1:0]         span_t;

  // one stack entry
  typedef struct packed {
    price_t value;
    span_t  span;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // latch accepted price, start span at one
    logic rd_en;  // read entry below the post-pop write pointer
    logic pop;    // drop top entry, add its span
    logic push;   // write new pair, hand result to output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cnt_zero;
    logic cnt_one;
    logic top_le;    // top entry value <= current price
    logic out_free;  // output register can take a result this cycle
  } sts_t;

endpackage

[sv/msspan_ctrl.sv]
module msspan_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  msspan_pkg::sts_t  sts,
  output msspan_pkg::cmd_t  cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_CMP  = 1'b1;

  logic state_r;
  logic state_nxt;
  logic do_pop;
  logic finish;

  assign in_ready = (state_r == S_IDLE);

  // last compare: stack empty, top is greater, or popping the only entry
  assign do_pop = !sts.cnt_zero && sts.top_le;
  assign finish = sts.cnt_zero || !sts.top_le || sts.cnt_one;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cmd.rd_en = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (!finish) begin
          cmd.pop   = 1'b1;
          cmd.rd_en = 1'b1;
        end else if (sts.out_free) begin
          cmd.pop   = do_pop;
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[sv/msspan_dp.sv]
module msspan_dp #(
  parameter int STACK_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  msspan_pkg::price_t   in_price,
  input  msspan_pkg::cmd_t     cmd,
  output msspan_pkg::sts_t     sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output msspan_pkg::span_t    out_span,
  output logic                 out_span_inexact
);

  localparam int PW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int SW = msspan_pkg::SPAN_W;
  localparam logic [PW-1:0] PTR_LAST = PW'(STACK_DEPTH - 1);
  localparam logic [PW-1:0] PTR_ZERO = '0;
  localparam logic [CW-1:0] CNT_FULL = CW'(STACK_DEPTH);

  msspan_pkg::entry_t mem [STACK_DEPTH];

  msspan_pkg::price_t price_r;
  msspan_pkg::span_t  span_r;
  logic               inexact_r;
  logic [PW-1:0]      wr_r, wr_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               ovf_r, ovf_nxt;
  msspan_pkg::entry_t rd_data_r;
  logic               out_valid_r;
  msspan_pkg::span_t  out_span_r;
  logic               out_inexact_r;

  logic [PW-1:0]      wr_dec, wr_pop, rd_addr;
  logic [CW-1:0]      cnt_pop;
  logic [SW:0]        span_sum;
  msspan_pkg::span_t  span_fin;

  // circular stack: wr_r is the next free slot; a push onto a full stack
  // lands on the oldest entry, which is the discard
  assign wr_dec   = (wr_r == PTR_ZERO) ? PTR_LAST : wr_r - PW'(1);
  assign wr_pop   = cmd.pop ? wr_dec : wr_r;
  assign rd_addr  = (wr_pop == PTR_ZERO) ? PTR_LAST : wr_pop - PW'(1);
  assign cnt_pop  = cmd.pop ? cnt_r - CW'(1) : cnt_r;

  assign span_sum = {1'b0, span_r} + {1'b0, rd_data_r.span};
  assign span_fin = !cmd.pop   ? span_r :
                    span_sum[SW] ? '1     : span_sum[SW-1:0];

  always_comb begin
    wr_nxt  = wr_r;
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (cmd.push) begin
      wr_nxt  = (wr_pop == PTR_LAST) ? PTR_ZERO : wr_pop + PW'(1);
      cnt_nxt = (cnt_pop == CNT_FULL) ? cnt_pop : cnt_pop + CW'(1);
      ovf_nxt = ovf_r | (cnt_pop == CNT_FULL);
    end else if (cmd.pop) begin
      wr_nxt  = wr_pop;
      cnt_nxt = cnt_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r        <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      price_r   <= in_price;
      span_r    <= SW'(1);
      inexact_r <= ovf_r;
    end else if (cmd.pop) begin
      span_r <= span_fin;
    end
    if (cmd.push) begin
      out_span_r    <= span_fin;
      out_inexact_r <= inexact_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_pop] <= '{value: price_r, span: span_fin};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign sts.cnt_zero = (cnt_r == '0);
  assign sts.cnt_one  = (cnt_r == CW'(1));
  assign sts.top_le   = (rd_data_r.value <= price_r);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_span         = out_span_r;
  assign out_span_inexact = out_inexact_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL) else $error("stack count beyond depth");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |=> ovf_r) else $error("overflow flag cleared");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> (cnt_r != '0)) else $error("pop on empty stack");

  a_push_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |=> out_valid_r) else $error("push did not present result");

  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push && !cmd.pop && cnt_r == CNT_FULL) |=> (ovf_r && cnt_r == CNT_FULL))
    else $error("full push did not discard");

endmodule

[sv/monotonic_stack_span.sv]
// Stock span over a stream of signed 32-bit values.
// Input channel: in_valid/in_ready/in_price. One transfer per value.
// Result channel: out_valid/out_ready/out_span/out_span_inexact. One
// transfer per input, in input order. out_span counts consecutive recent
// values (this one included) not above in_price, saturating at all ones.
// out_span_inexact is set once the stack has ever overflowed.
// Timing: the accept cycle issues a read of the stack top; each following
// cycle compares one entry, popping it and reading the next one down while
// the compare does not finish. Entries are read through the single read
// port of the stack memory. When the pops empty the stack, the last pop
// merges with the push; the result is visible the cycle after the last
// compare. Each value is popped at most once.
// in_ready is high only between items. The output register lets the next
// value be taken while a result waits; if out_ready stays low the block
// holds at the final compare until the register frees.
// Reset empties the stack and clears the overflow flag at once; the memory
// itself is not cleared (only entries below the count are ever used).
// A full stack overwrites its oldest entry on push.
module monotonic_stack_span #(
  parameter int STACK_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  msspan_pkg::price_t  in_price,
  output logic                out_valid,
  input  logic                out_ready,
  output msspan_pkg::span_t   out_span,
  output logic                out_span_inexact
);

  msspan_pkg::cmd_t cmd;  // sequencer commands
  msspan_pkg::sts_t sts;  // stack and output status

  msspan_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  msspan_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_price         (in_price),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_span         (out_span),
    .out_span_inexact (out_span_inexact)
  );

endmodule
